// File: hdl/msc_pkg.sv
// msc_pkg: shared types, register codes and helpers for the media streaming coprocessor.
// Used by msc_ctrl and media_streaming_coprocessor; no dependencies.
`timescale 1ns / 1ps

package msc_pkg;

  // Hardware revision reported in the status byte and ID string
  localparam logic [2:0] REVISION = 3'd1;

  // Word widths on the streams
  localparam int IN_W  = 88;
  localparam int OUT_W = 128;

  // Item kinds carried on in_tuser
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Read map
  localparam logic [2:0] RD_STATUS = 3'd0;
  localparam logic [2:0] RD_DATA   = 3'd1;
  localparam logic [2:0] RD_ID0    = 3'd2;
  localparam logic [2:0] RD_ID1    = 3'd3;
  localparam logic [2:0] RD_ID2    = 3'd4;
  localparam logic [2:0] RD_ID3    = 3'd5;
  localparam logic [2:0] RD_ID4    = 3'd6;
  localparam logic [2:0] RD_REV    = 3'd7;

  // Write map
  localparam logic [2:0] WR_OFS0    = 3'd0;
  localparam logic [2:0] WR_OFS1    = 3'd1;
  localparam logic [2:0] WR_OFS2    = 3'd2;
  localparam logic [2:0] WR_OFS3    = 3'd3;
  localparam logic [2:0] WR_TRK_LO  = 3'd4;
  localparam logic [2:0] WR_TRK_HI  = 3'd5;
  localparam logic [2:0] WR_VOLUME  = 3'd6;
  localparam logic [2:0] WR_CONTROL = 3'd7;

  // Status flag bit positions
  localparam int F_DBUSY  = 4;
  localparam int F_ABUSY  = 3;
  localparam int F_REPEAT = 2;
  localparam int F_PLAY   = 1;
  localparam int F_ERROR  = 0;

  localparam logic [4:0]  FLAGS_RESET = 5'h18;
  localparam logic [7:0]  VOLUME_RESET = 8'hff;
  // Audio stream starts past its 8-byte header
  localparam logic [31:0] AUDIO_START = 32'd8;
  localparam logic [31:0] SAMPLE_BYTES = 32'd4;

  // Input word, last field in the lowest bits
  typedef struct packed {
    logic               pad;
    logic               mute;
    logic               audio_at_end;
    logic signed [15:0] sample_right;
    logic signed [15:0] sample_left;
    logic [31:0]        track_loop_samples;
    logic               track_file_ok;
    logic               data_file_open;
    logic [7:0]         data_file_byte;
    logic [7:0]         write_data;
    logic [2:0]         reg_index;
  } in_item_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [2:0]         pad;
    logic [15:0]        track_number;
    logic               track_open_request;
    logic               audio_sample_taken;
    logic [31:0]        audio_offset_now;
    logic               audio_seek_request;
    logic               data_byte_taken;
    logic [31:0]        data_offset_now;
    logic               data_seek_request;
    logic signed [15:0] out_right;
    logic signed [15:0] out_left;
    logic [7:0]         read_data;
  } out_item_t;

  // Decoded result of one command from the register block
  typedef struct packed {
    logic [7:0]         read_data;
    logic               data_seek_request;
    logic [31:0]        data_offset_now;
    logic               data_byte_taken;
    logic               audio_seek_request;
    logic [31:0]        audio_offset_now;
    logic               audio_sample_taken;
    logic               track_open_request;
    logic [15:0]        track_number;
    logic signed [15:0] smp_left;
    logic signed [15:0] smp_right;
    logic [7:0]         volume;
  } ctrl_res_t;

  // ID string bytes "S-MSU" then the revision digit
  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      RD_ID0:  b = 8'h53;
      RD_ID1:  b = 8'h2d;
      RD_ID2:  b = 8'h4d;
      RD_ID3:  b = 8'h53;
      RD_ID4:  b = 8'h55;
      RD_REV:  b = 8'h30 + {5'd0, REVISION};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Unsigned x / 255, truncating, for x up to 32768 * 255.
  // Estimate by x/256 + x/65536, then correct with the remainder (below 4 * 255).
  function automatic logic [15:0] div255(input logic [23:0] x);
    logic [16:0] q0;
    logic [24:0] rem;
    logic [9:0]  rs;
    logic [1:0]  c;
    q0  = 17'(x[23:8]) + 17'(x[23:16]);
    rem = 25'(x) + 25'(q0) - {q0, 8'h00};
    rs  = rem[9:0];
    c   = {1'b0, rs >= 10'd255} + {1'b0, rs >= 10'd510} + {1'b0, rs >= 10'd765};
    return 16'(q0 + 17'(c));
  endfunction

endpackage

// File: hdl/msc_ctrl.sv
// msc_ctrl: bus register file and sequencing state of the media streaming coprocessor.
// Decodes one read, write or tick per fire and updates the offsets, track, volume and flags.
// Depends on msc_pkg.
`timescale 1ns / 1ps

module msc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_fire,
  input  logic [1:0]          cmd_op,
  input  msc_pkg::in_item_t   cmd_item,
  output msc_pkg::ctrl_res_t  res
);
  import msc_pkg::*;

  logic [31:0] dpos_r, dpos_nxt;
  logic [31:0] apos_r, apos_nxt;
  logic [31:0] loop_r, loop_nxt;
  logic [15:0] trk_r, trk_nxt;
  logic [7:0]  vol_r, vol_nxt;
  logic [4:0]  flags_r, flags_nxt;
  logic        open_r, open_nxt;

  logic [7:0]  rd;
  logic        dseek, dtaken, aseek, ataken, topen;
  logic [2:0]  idx;
  logic [7:0]  wd;

  assign idx = cmd_item.reg_index;
  assign wd  = cmd_item.write_data;

  // State registers, updated once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpos_r  <= '0;
      apos_r  <= '0;
      loop_r  <= '0;
      trk_r   <= '0;
      vol_r   <= VOLUME_RESET;
      flags_r <= FLAGS_RESET;
      open_r  <= 1'b0;
    end else if (cmd_fire) begin
      dpos_r  <= dpos_nxt;
      apos_r  <= apos_nxt;
      loop_r  <= loop_nxt;
      trk_r   <= trk_nxt;
      vol_r   <= vol_nxt;
      flags_r <= flags_nxt;
      open_r  <= open_nxt;
    end
  end

  // Command decode
  always_comb begin
    dpos_nxt  = dpos_r;
    apos_nxt  = apos_r;
    loop_nxt  = loop_r;
    trk_nxt   = trk_r;
    vol_nxt   = vol_r;
    flags_nxt = flags_r;
    open_nxt  = open_r;
    rd        = 8'h00;
    dseek     = 1'b0;
    dtaken    = 1'b0;
    aseek     = 1'b0;
    ataken    = 1'b0;
    topen     = 1'b0;
    unique case (cmd_op)
      OP_READ: begin
        unique case (idx)
          RD_STATUS: rd = {flags_r, REVISION};
          RD_DATA: begin
            // data port only moves once the seek has finished
            if (!flags_r[F_DBUSY]) begin
              dpos_nxt = dpos_r + 32'd1;
              if (cmd_item.data_file_open) begin
                rd     = cmd_item.data_file_byte;
                dtaken = 1'b1;
              end
            end
          end
          default: rd = id_byte(idx);
        endcase
      end
      OP_WRITE: begin
        unique case (idx)
          WR_OFS0: dpos_nxt[7:0]   = wd;
          WR_OFS1: dpos_nxt[15:8]  = wd;
          WR_OFS2: dpos_nxt[23:16] = wd;
          WR_OFS3: begin
            dpos_nxt[31:24]    = wd;
            dseek              = cmd_item.data_file_open;
            flags_nxt[F_DBUSY] = 1'b0;
          end
          WR_TRK_LO: trk_nxt[7:0] = wd;
          WR_TRK_HI: begin
            trk_nxt[15:8] = wd;
            topen         = 1'b1;
            open_nxt      = cmd_item.track_file_ok;
            if (cmd_item.track_file_ok) begin
              apos_nxt = AUDIO_START;
              loop_nxt = AUDIO_START + {cmd_item.track_loop_samples[29:0], 2'b00};
            end
            // only data busy survives a track change; error marks a failed open
            flags_nxt          = '0;
            flags_nxt[F_DBUSY] = flags_r[F_DBUSY];
            flags_nxt[F_ERROR] = !cmd_item.track_file_ok;
          end
          WR_VOLUME: vol_nxt = wd;
          WR_CONTROL: begin
            flags_nxt[F_REPEAT] = wd[1];
            flags_nxt[F_PLAY]   = wd[0];
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (flags_r[F_PLAY]) begin
          if (open_r) begin
            if (cmd_item.audio_at_end) begin
              // end of stream: loop back or stop at the start
              if (!flags_r[F_REPEAT]) begin
                flags_nxt[F_PLAY] = 1'b0;
                apos_nxt          = AUDIO_START;
              end else begin
                apos_nxt = loop_r;
              end
              aseek = 1'b1;
            end else begin
              apos_nxt = apos_r + SAMPLE_BYTES;
              ataken   = 1'b1;
            end
          end else begin
            flags_nxt[F_PLAY] = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Result offsets and track reflect the state after this word; volume the state before
  always_comb begin
    res.read_data          = rd;
    res.data_seek_request  = dseek;
    res.data_offset_now    = dpos_nxt;
    res.data_byte_taken    = dtaken;
    res.audio_seek_request = aseek;
    res.audio_offset_now   = apos_nxt;
    res.audio_sample_taken = ataken;
    res.track_open_request = topen;
    res.track_number       = trk_nxt;
    res.smp_left           = ataken ? cmd_item.sample_left : 16'sd0;
    res.smp_right          = ataken ? cmd_item.sample_right : 16'sd0;
    res.volume             = vol_r;
  end

  // A data byte is only consumed once the data port is out of busy
  a_dtaken_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_fire && res.data_byte_taken |-> !flags_r[F_DBUSY])
    else $error("data byte taken while data busy");

  // Writing the top offset byte always clears data busy
  a_ofs3_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_fire && cmd_op == OP_WRITE && idx == WR_OFS3 |=> !flags_r[F_DBUSY])
    else $error("data busy still set after offset write");

  // Successful track open rewinds the audio stream past its header
  a_open_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_fire && cmd_op == OP_WRITE && idx == WR_TRK_HI && cmd_item.track_file_ok
    |=> open_r && apos_r == AUDIO_START && !flags_r[F_PLAY])
    else $error("track open did not rewind audio offset");

endmodule

// File: hdl/media_streaming_coprocessor.sv
// Media streaming coprocessor: top level with input, product and result pipeline registers.
// Instantiates msc_ctrl; uses msc_pkg for word layouts and the divide-by-255 helper.
//
// Usage: each input word is one bus read, bus write or sample tick (kind on in_tuser),
// with the bus and stream fields on in_tdata. Every accepted word yields exactly one
// result word on out_tdata: read data, scaled stereo samples and the seek, offset and
// track-open requests that the data store and audio stream must act on.
// Each accepted word passes the input register, then the product register, then the result
// register before it appears on out_tvalid. Throughput: one word per cycle unless
// out_tready stalls the pipeline; the register state is updated as a word leaves the
// input register, and the 16x8 volume product is registered before the divide by 255.
// Reset (synchronous, rst_n low) empties the pipeline and sets data offset, audio offset,
// loop offset and track to zero, volume to 255 and both busy flags; zero writes to the
// offset and track registers are left to the driver.
// When the receiver holds out_tready low, the result is held and the pipeline fills;
// in_tready falls only once all three registers hold words.
`timescale 1ns / 1ps

module media_streaming_coprocessor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // reg_index, write_data, data_file_byte, data_file_open, track_file_ok,
  // track_loop_samples, sample_left, sample_right, audio_at_end, mute, 1 pad bit
  input  logic [msc_pkg::IN_W-1:0]    in_tdata,
  // opcode
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // read_data, out_left, out_right, data_seek_request, data_offset_now, data_byte_taken,
  // audio_seek_request, audio_offset_now, audio_sample_taken, track_open_request,
  // track_number, 3 pad bits
  output logic [msc_pkg::OUT_W-1:0]   out_tdata
);
  import msc_pkg::*;

  // Product stage contents
  typedef struct packed {
    logic [7:0]  read_data;
    logic        data_seek_request;
    logic [31:0] data_offset_now;
    logic        data_byte_taken;
    logic        audio_seek_request;
    logic [31:0] audio_offset_now;
    logic        audio_sample_taken;
    logic        track_open_request;
    logic [15:0] track_number;
    logic [23:0] prod_l;
    logic [23:0] prod_r;
    logic        neg_l;
    logic        neg_r;
    logic        mute;
  } mid_t;

  logic       s1_v_r, s1_v_nxt;
  in_item_t   s1_item_r;
  logic [1:0] s1_op_r;
  logic       mid_v_r, mid_v_nxt;
  mid_t       mid_r, mid_nxt;
  logic       out_v_r, out_v_nxt;
  out_item_t  out_r, out_nxt;

  logic       in_fire, s1_adv, mid_adv, mid_ready, out_ready;
  ctrl_res_t  cres;
  logic [15:0] mag_l, mag_r, q_l, q_r;

  // Handshake chain: each register loads when empty or draining
  assign out_ready = !out_v_r || out_tready;
  assign mid_ready = !mid_v_r || out_ready;
  assign mid_adv   = mid_v_r && out_ready;
  assign s1_adv    = s1_v_r && mid_ready;
  assign in_tready = !s1_v_r || mid_ready;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_v_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign mid_v_nxt = s1_adv ? 1'b1 : (mid_adv ? 1'b0 : mid_v_r);
  assign out_v_nxt = mid_adv ? 1'b1 : ((out_v_r && out_tready) ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      mid_v_r <= mid_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item_t'(in_tdata);
      s1_op_r   <= in_tuser;
    end
    if (s1_adv) begin
      mid_r <= mid_nxt;
    end
    if (mid_adv) begin
      out_r <= out_nxt;
    end
  end

  msc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_fire (s1_adv),
    .cmd_op   (s1_op_r),
    .cmd_item (s1_item_r),
    .res      (cres)
  );

  // Sample magnitude times volume
  assign mag_l = cres.smp_left[15]  ? (~cres.smp_left + 16'd1)  : cres.smp_left;
  assign mag_r = cres.smp_right[15] ? (~cres.smp_right + 16'd1) : cres.smp_right;

  always_comb begin
    mid_nxt.read_data          = cres.read_data;
    mid_nxt.data_seek_request  = cres.data_seek_request;
    mid_nxt.data_offset_now    = cres.data_offset_now;
    mid_nxt.data_byte_taken    = cres.data_byte_taken;
    mid_nxt.audio_seek_request = cres.audio_seek_request;
    mid_nxt.audio_offset_now   = cres.audio_offset_now;
    mid_nxt.audio_sample_taken = cres.audio_sample_taken;
    mid_nxt.track_open_request = cres.track_open_request;
    mid_nxt.track_number       = cres.track_number;
    mid_nxt.prod_l             = 24'(mag_l) * 24'(cres.volume);
    mid_nxt.prod_r             = 24'(mag_r) * 24'(cres.volume);
    mid_nxt.neg_l              = cres.smp_left[15];
    mid_nxt.neg_r              = cres.smp_right[15];
    mid_nxt.mute               = s1_item_r.mute && s1_op_r == OP_TICK;
  end

  // Divide by 255 toward zero, restore sign, apply mute
  assign q_l = div255(mid_r.prod_l);
  assign q_r = div255(mid_r.prod_r);

  always_comb begin
    out_nxt.pad                = '0;
    out_nxt.track_number       = mid_r.track_number;
    out_nxt.track_open_request = mid_r.track_open_request;
    out_nxt.audio_sample_taken = mid_r.audio_sample_taken;
    out_nxt.audio_offset_now   = mid_r.audio_offset_now;
    out_nxt.audio_seek_request = mid_r.audio_seek_request;
    out_nxt.data_byte_taken    = mid_r.data_byte_taken;
    out_nxt.data_offset_now    = mid_r.data_offset_now;
    out_nxt.data_seek_request  = mid_r.data_seek_request;
    out_nxt.read_data          = mid_r.read_data;
    out_nxt.out_left           = mid_r.mute ? 16'sd0 : (mid_r.neg_l ? -q_l : q_l);
    out_nxt.out_right          = mid_r.mute ? 16'sd0 : (mid_r.neg_r ? -q_r : q_r);
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  // Muted tick results carry silent samples
  a_mute_silent: assert property (@(posedge clk) disable iff (!rst_n)
    mid_adv && mid_r.mute |=> out_r.out_left == 16'sd0 && out_r.out_right == 16'sd0)
    else $error("muted tick produced nonzero samples");

  // Samples are only nonzero when a sample pair was consumed
  a_samples_need_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.audio_sample_taken |-> out_r.out_left == 16'sd0 &&
    out_r.out_right == 16'sd0)
    else $error("samples present without a consumed sample pair");

endmodule
